// ===== hw/rtl/salc_pkg.sv =====
// Shared constants, types and functions of the LRU cache prefetch unit.
`timescale 1ns / 1ps
package salc_pkg;
    localparam int CacheBytes = 16384;
    localparam int LineBytes  = 32;
    localparam int Ways       = 4;
    localparam int AddrW      = 32;
    localparam int CountW     = 32;
    localparam int WayW       = 4;
    localparam int CfgIdxW    = 1;
    localparam int CfgDataW   = 2;

    localparam logic [CfgIdxW-1:0] CFG_WRITE_ALLOCATE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PREFETCH_MODE  = 1'd1;

    localparam logic [1:0] PF_NONE = 2'd0;
    localparam logic [1:0] PF_ALL  = 2'd1;
    localparam logic [1:0] PF_MISS = 2'd2;

    typedef struct packed {
        logic [AddrW-1:0] address;
        logic             req_type;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [WayW-1:0]   demand_way;
        logic              demand_filled;
        logic              prefetch_filled;
        logic [CountW-1:0] hit_count;
    } t_rsp;

    function automatic int flog2(input int v);
        int n;
        n = 0;
        for (int k = 0; k < 32; k++) begin
            if ((v >> (k + 1)) > 0) n = k + 1;
        end
        return n;
    endfunction
endpackage

// ===== hw/rtl/salc_if.sv =====
// Valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface salc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_prefetch_unit.sv =====
// Top level: LRU set-associative tag engine with next-line prefetch.
// Each request takes a read and an update state, plus a second pair when a prefetch runs.
// A new request is taken only after the last result is in the output register; one set
// memory port. Reset clears valid bits and sets ranks to way order, one set per cycle over
// all 128 sets by default, and takes no request meanwhile; config writes are always taken.
`timescale 1ns / 1ps
module set_assoc_lru_cache_prefetch_unit #(
    parameter int CACHE_BYTES = salc_pkg::CacheBytes,
    parameter int LINE_BYTES  = salc_pkg::LineBytes,
    parameter int WAYS        = salc_pkg::Ways
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [salc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [salc_pkg::CfgDataW-1:0] i_cfg_data,
    salc_if.sink                          s_req,
    salc_if.source                        m_rsp
);
    localparam int OB    = salc_pkg::flog2(LINE_BYTES);
    localparam int SRAW  = CACHE_BYTES / (LINE_BYTES * WAYS);
    localparam int SETS  = (SRAW > 0) ? SRAW : 1;
    localparam int IB    = salc_pkg::flog2(SETS);
    localparam int IW    = (IB > 0) ? IB : 1;
    localparam int TW    = salc_pkg::AddrW - OB - IB;
    localparam int RW    = $clog2(WAYS);
    localparam int DEPTH = 1 << IB;

    localparam logic [2:0] ST_CLR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DRD = 3'd2;
    localparam logic [2:0] ST_DUP = 3'd3;
    localparam logic [2:0] ST_PRD = 3'd4;
    localparam logic [2:0] ST_PUP = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    typedef struct packed {
        logic [WAYS-1:0]         vld;
        logic [WAYS-1:0][TW-1:0] tag;
        logic [WAYS-1:0][RW-1:0] rank;
    } t_set;

    t_set r_mem [DEPTH];
    t_set r_rd;

    logic [2:0]                     r_st, n_st;
    logic [IW:0]                    r_clr;
    logic                           r_wa;
    logic [1:0]                     r_pm;
    logic [salc_pkg::AddrW-1:0]     r_addr;
    logic                           r_store;
    logic [salc_pkg::CountW-1:0]    r_hits;
    salc_pkg::t_rsp                 r_acc;
    salc_pkg::t_rsp                 r_rsp;
    logic                           r_vout;

    logic [salc_pkg::AddrW-1:0] w_pfa, w_la;
    logic [IW-1:0]              w_idx;
    logic [TW-1:0]              w_tag;
    logic                       w_hit, w_fill, w_pf;
    logic [RW-1:0]              w_hway, w_vic, w_way;
    t_set                       w_new, w_clr;
    logic                       w_we;
    logic [IW-1:0]              w_widx;
    logic [salc_pkg::CountW-1:0] w_hits_nx;

    assign w_pfa = r_addr + salc_pkg::AddrW'(LINE_BYTES);
    assign w_la  = (r_st == ST_DRD || r_st == ST_DUP) ? r_addr : w_pfa;
    if (IB > 0) begin : g_idx
        assign w_idx = w_la[OB +: IW];
    end else begin : g_noidx
        assign w_idx = '0;
    end
    assign w_tag = w_la[salc_pkg::AddrW-1 -: TW];

    always_comb begin
        w_hit  = 1'b0;
        w_hway = '0;
        w_vic  = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (r_rd.vld[k] && r_rd.tag[k] == w_tag) begin
                w_hit  = 1'b1;
                w_hway = RW'(k);
            end
            if (r_rd.rank[k] == '0) w_vic = RW'(k);
        end
        w_fill = !w_hit && (r_st == ST_PUP || !r_store || r_wa);
        w_way  = w_hit ? w_hway : w_vic;
        w_new  = r_rd;
        for (int k = 0; k < WAYS; k++) begin
            if (r_rd.rank[k] > r_rd.rank[w_way]) w_new.rank[k] = r_rd.rank[k] - 1'b1;
        end
        w_new.rank[w_way] = RW'(WAYS - 1);
        if (w_fill) begin
            w_new.vld[w_way] = 1'b1;
            w_new.tag[w_way] = w_tag;
        end
        w_pf = (r_pm == salc_pkg::PF_ALL) || (r_pm == salc_pkg::PF_MISS && !w_hit);
        w_clr = '0;
        for (int k = 0; k < WAYS; k++) w_clr.rank[k] = RW'(k);
    end

    assign w_hits_nx = (r_st == ST_DUP && w_hit && r_hits != '1) ? r_hits + 1'b1 : r_hits;

    assign w_we   = (r_st == ST_CLR) || ((r_st == ST_DUP) && (w_hit || w_fill))
                    || (r_st == ST_PUP);
    assign w_widx = (r_st == ST_CLR) ? r_clr[IW-1:0] : w_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_widx] <= (r_st == ST_CLR) ? w_clr : w_new;
        r_rd <= r_mem[w_idx];
    end

    assign s_req.ready = (r_st == ST_IDLE);
    assign m_rsp.valid = r_vout;
    assign m_rsp.data  = r_rsp;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLR:  if (r_clr == (IW+1)'(DEPTH - 1)) n_st = ST_IDLE;
            ST_IDLE: if (s_req.valid) n_st = ST_DRD;
            ST_DRD:  n_st = ST_DUP;
            ST_DUP:  n_st = w_pf ? ST_PRD : ST_OUT;
            ST_PRD:  n_st = ST_PUP;
            ST_PUP:  n_st = ST_OUT;
            ST_OUT:  if (!r_vout || m_rsp.ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLR;
            r_clr  <= '0;
            r_wa   <= 1'b1;
            r_pm   <= salc_pkg::PF_NONE;
            r_hits <= '0;
            r_vout <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_idx == salc_pkg::CFG_WRITE_ALLOCATE) r_wa <= i_cfg_data[0];
                if (i_cfg_idx == salc_pkg::CFG_PREFETCH_MODE)  r_pm <= i_cfg_data;
            end
            r_hits <= w_hits_nx;
            if (r_st == ST_OUT && (!r_vout || m_rsp.ready)) r_vout <= 1'b1;
            else if (m_rsp.ready) r_vout <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && s_req.valid) begin
            r_addr  <= s_req.data.address;
            r_store <= s_req.data.req_type;
        end
        if (r_st == ST_DUP) begin
            r_acc.hit             <= w_hit;
            r_acc.demand_way      <= (w_hit || w_fill) ? salc_pkg::WayW'(w_way) : '0;
            r_acc.demand_filled   <= w_fill;
            r_acc.prefetch_filled <= 1'b0;
            r_acc.hit_count       <= w_hits_nx;
        end
        if (r_st == ST_PUP) r_acc.prefetch_filled <= w_fill;
        if (r_st == ST_OUT && (!r_vout || m_rsp.ready)) r_rsp <= r_acc;
    end

`ifndef SYNTHESIS
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_CLR |-> !s_req.ready) else $error("request taken during clear");
    a_rank_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DUP || r_st == ST_PUP) |-> w_new.rank[w_way] == RW'(WAYS - 1))
        else $error("touched way not most recent");
    a_fill_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DUP && w_fill |-> !w_hit) else $error("fill on hit");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vout && !m_rsp.ready |=> r_vout) else $error("result dropped");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vout && !m_rsp.ready |=> $stable(r_rsp)) else $error("result changed while held");
`endif
endmodule

// ===== sim/set_assoc_lru_cache_prefetch_unit_tb.sv =====
// Self-checking testbench of the LRU cache tag engine with next-line prefetch.
`timescale 1ns / 1ps
module set_assoc_lru_cache_prefetch_unit_tb;
    localparam int OffW    = $clog2(salc_pkg::LineBytes);
    localparam int NumSets = salc_pkg::CacheBytes / (salc_pkg::LineBytes * salc_pkg::Ways);
    localparam int IdxW    = $clog2(NumSets);
    localparam int NumLines = NumSets * salc_pkg::Ways;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 12;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef struct {
        t_row_kind                  kind;
        logic [salc_pkg::AddrW-1:0] address;
        logic                       req_type;
        logic                       known;
        salc_pkg::t_rsp             exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [salc_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [salc_pkg::CfgDataW-1:0] i_cfg_data = '0;

    salc_if #(.T(salc_pkg::t_req)) req_ch();
    salc_if #(.T(salc_pkg::t_rsp)) rsp_ch();

    set_assoc_lru_cache_prefetch_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .s_req(req_ch.sink), .m_rsp(rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bit                          line_ok [NumLines];
    logic [salc_pkg::AddrW-1:0]  line_tag [NumLines];
    int unsigned                 line_rank [NumLines];
    logic [salc_pkg::CountW-1:0] hits_seen;
    logic                        alloc_on_store;
    logic [1:0]                  pf_mode;

    salc_pkg::t_rsp expected_rsp[$];
    logic known_q[$];
    salc_pkg::t_rsp known_rsp[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles = 0;
    bit   hold_rsp = 0;
    bit   stim_done = 0;

    function automatic void promote(input int base, input int way);
        int old;
        old = line_rank[base + way];
        for (int k = 0; k < salc_pkg::Ways; k++)
            if (line_rank[base + k] > old) line_rank[base + k]--;
        line_rank[base + way] = salc_pkg::Ways - 1;
    endfunction

    function automatic bit lookup_line(input logic [salc_pkg::AddrW-1:0] a, input bit may_fill,
                                       output logic [salc_pkg::WayW-1:0] way,
                                       output bit filled);
        int base;
        int victim;
        logic [salc_pkg::AddrW-1:0] tg;
        base = int'((a >> OffW) & (NumSets - 1)) * salc_pkg::Ways;
        tg = a >> (OffW + IdxW);
        victim = 0;
        filled = 0;
        for (int k = 0; k < salc_pkg::Ways; k++)
            if (line_ok[base + k] && line_tag[base + k] == tg) begin
                promote(base, k);
                way = salc_pkg::WayW'(k);
                return 1;
            end
        way = 0;
        if (!may_fill) return 0;
        for (int k = salc_pkg::Ways - 1; k >= 0; k--)
            if (line_rank[base + k] == 0) victim = k;
        line_ok[base + victim] = 1;
        line_tag[base + victim] = tg;
        promote(base, victim);
        way = salc_pkg::WayW'(victim);
        filled = 1;
        return 0;
    endfunction

    function automatic salc_pkg::t_rsp predict_lookup(input salc_pkg::t_req r);
        salc_pkg::t_rsp o;
        logic [salc_pkg::WayW-1:0] pw;
        bit df;
        bit pf;
        o = '0;
        o.hit = lookup_line(r.address, !r.req_type || alloc_on_store, o.demand_way, df);
        o.demand_filled = df;
        if (o.hit && hits_seen != '1) hits_seen++;
        if (pf_mode == salc_pkg::PF_ALL || (pf_mode == salc_pkg::PF_MISS && !o.hit)) begin
            void'(lookup_line(r.address + salc_pkg::AddrW'(salc_pkg::LineBytes), 1, pw, pf));
            o.prefetch_filled = pf;
        end
        o.hit_count = hits_seen;
        return o;
    endfunction

    initial begin
        for (int i = 0; i < NumLines; i++) begin
            line_ok[i] = 0;
            line_tag[i] = '0;
            line_rank[i] = i % salc_pkg::Ways;
        end
        hits_seen = '0;
        alloc_on_store = 1;
        pf_mode = salc_pkg::PF_NONE;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("set_assoc_lru_cache_prefetch_unit_tb: FAIL");
            $finish;
        end
        if (req_ch.valid && req_ch.ready) expected_rsp.push_back(predict_lookup(req_ch.data));
        if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
            end else begin
                salc_pkg::t_rsp e;
                salc_pkg::t_rsp k_rsp;
                logic k_on;
                e = expected_rsp.pop_front();
                if (known_q.size() > 0) begin
                    k_on = known_q.pop_front();
                    k_rsp = known_rsp.pop_front();
                    if (k_on && k_rsp !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row disagrees with predictor: exp %p got %p",
                                     k_rsp, e);
                    end
                end
                if (rsp_ch.data.hit !== e.hit || rsp_ch.data.demand_way !== e.demand_way ||
                    rsp_ch.data.demand_filled !== e.demand_filled ||
                    rsp_ch.data.prefetch_filled !== e.prefetch_filled ||
                    rsp_ch.data.hit_count !== e.hit_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: exp %p got %p",
                                 results_seen, e, rsp_ch.data);
                end
            end
        end
    end

    initial begin
        int n;
        bit calm;
        rsp_ch.ready = 1'b0;
        forever begin
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_rsp = 0;
            end
            calm = ($urandom_range(0, 3) == 0);
            n = calm ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [salc_pkg::CfgIdxW-1:0] idx,
                             input logic [salc_pkg::CfgDataW-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        if (idx == salc_pkg::CFG_WRITE_ALLOCATE) alloc_on_store = v[0];
        else pf_mode = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one request; when gap is zero, valid stays high and the next one is driven right after this one is taken.
    task automatic send_req(input salc_pkg::t_req r);
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            if (req_ch.valid) req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    function automatic salc_pkg::t_req random_req();
        salc_pkg::t_req r;
        int pick;
        pick = $urandom_range(0, 9);
        r.req_type = 1'($urandom_range(0, 1));
        if (pick < 7) begin
            r.address = {12'($urandom_range(0, 7)), 8'($urandom_range(0, 3)),
                         IdxW'($urandom_range(0, 3)), OffW'($urandom)};
            if ($urandom_range(0, 1)) r.address[31:28] = 4'hF;
        end else begin
            r.address = $urandom;
        end
        return r;
    endfunction

    t_row rows[$];
    logic [1:0] pf_plan[7] = '{salc_pkg::PF_NONE, salc_pkg::PF_ALL, salc_pkg::PF_MISS, 2'd3,
                               salc_pkg::PF_ALL, salc_pkg::PF_MISS, salc_pkg::PF_NONE};
    logic       wa_plan[7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    function automatic void add_req(input logic [31:0] a, input logic st);
        rows.push_back('{ROW_REQ, a, st, 1'b0, salc_pkg::t_rsp'('0)});
    endfunction

    function automatic void add_cfg(input logic [salc_pkg::CfgIdxW-1:0] idx,
                                    input logic [1:0] v);
        rows.push_back('{ROW_CFG, 32'(v), logic'(idx), 1'b0, salc_pkg::t_rsp'('0)});
    endfunction

    initial begin
        salc_pkg::t_req r;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rows.push_back('{ROW_REQ, 32'h0, 1'b0, 1'b1,
                         salc_pkg::t_rsp'{1'b0, 4'd0, 1'b1, 1'b0, 32'd0}});
        rows.push_back('{ROW_REQ, 32'h1F, 1'b0, 1'b1,
                         salc_pkg::t_rsp'{1'b1, 4'd0, 1'b0, 1'b0, 32'd1}});
        rows.push_back('{ROW_REQ, 32'hFFFF_FFFF, 1'b0, 1'b1,
                         salc_pkg::t_rsp'{1'b0, 4'd0, 1'b1, 1'b0, 32'd1}});
        add_req(32'h1000, 1'b1);
        add_req(32'h2000, 1'b0);
        add_req(32'h3000, 1'b0);
        add_req(32'h4000, 1'b0);
        add_req(32'h1004, 1'b0);
        add_cfg(salc_pkg::CFG_WRITE_ALLOCATE, 2'd0);
        add_req(32'h8000, 1'b1);
        add_req(32'h8000, 1'b0);
        add_cfg(salc_pkg::CFG_PREFETCH_MODE, salc_pkg::PF_ALL);
        add_req(32'hFFFF_FFE0, 1'b0);
        add_req(32'h0000_0020, 1'b0);
        add_cfg(salc_pkg::CFG_PREFETCH_MODE, salc_pkg::PF_MISS);
        add_req(32'h0000_0020, 1'b0);
        add_req(32'h5000, 1'b0);
        add_req(32'h9000, 1'b1);
        add_cfg(salc_pkg::CFG_PREFETCH_MODE, 2'd3);
        add_req(32'hA000, 1'b0);
        add_cfg(salc_pkg::CFG_WRITE_ALLOCATE, 2'd1);
        add_cfg(salc_pkg::CFG_PREFETCH_MODE, salc_pkg::PF_NONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].req_type, rows[i].address[1:0]);
            end else begin
                known_q.push_back(rows[i].known);
                known_rsp.push_back(rows[i].exp);
                r.address = rows[i].address;
                r.req_type = rows[i].req_type;
                send_req(r);
            end
        end
        req_ch.valid <= 1'b0;

        for (int p = 0; p < 7; p++) begin
            write_reg(salc_pkg::CFG_WRITE_ALLOCATE, {1'b0, wa_plan[p]});
            write_reg(salc_pkg::CFG_PREFETCH_MODE, pf_plan[p]);
            for (int i = 0; i < 100; i++) begin
                if (p == 3 && i == 50) begin
                    req_ch.valid <= 1'b0;
                    while (expected_rsp.size() > 0) @(posedge i_clk);
                end
                if (p == 1 && i == 20) hold_rsp = 1;
                send_req(random_req());
            end
            req_ch.valid <= 1'b0;
        end

        drain();
        $display("ran %0d requests over %0d cycles: directed table plus seven config phases",
                 results_seen, cycles);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("set_assoc_lru_cache_prefetch_unit_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_rsp.size());
            $display("set_assoc_lru_cache_prefetch_unit_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/salc_pkg.sv
hw/rtl/salc_if.sv
hw/rtl/set_assoc_lru_cache_prefetch_unit.sv
sim/set_assoc_lru_cache_prefetch_unit_tb.sv
